### design/length_prefixed_request_parser_top_defines.svh
`ifndef LENGTH_PREFIXED_REQUEST_PARSER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_REQUEST_PARSER_TOP_DEFINES_SVH

// checks sampled on clk, off while reset is held
`define LPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checks sampled on clk, also during reset
`define LPP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/lpp_pkg.sv
package lpp_pkg;

  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_CNT  = 4'b0010,
    PH_SIZE = 4'b0100,
    PH_DATA = 4'b1000
  } phase_t;

  typedef logic [2:0] verdict_t;

  localparam verdict_t V_GET      = 3'd0;
  localparam verdict_t V_SET      = 3'd1;
  localparam verdict_t V_DEL      = 3'd2;
  localparam verdict_t V_UNKNOWN  = 3'd3;
  localparam verdict_t V_TOO_LONG = 3'd4;
  localparam verdict_t V_BAD      = 3'd5;

  localparam logic REG_MAX_BODY_LEN  = 1'b0;
  localparam logic REG_MAX_ARG_COUNT = 1'b1;

  localparam logic [31:0] MAX_BODY_LEN_RST  = 32'd4096;
  localparam logic [15:0] MAX_ARG_COUNT_RST = 16'd1024;

  typedef struct packed {
    logic [31:0] max_body_len;
    logic [15:0] max_arg_count;
  } cfg_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [15:0] arg_index;
    logic       arg_first;
    logic       arg_last;
    logic       frame_done;
    verdict_t   verdict;
  } result_t;

  // command names, lower case: k 0 get, 1 set, 2 del
  function automatic logic [7:0] cmd_char(input logic [1:0] k, input logic [1:0] pos);
    logic [23:0] name;
    unique case (k)
      2'd0:    name = 24'h676574;
      2'd1:    name = 24'h736574;
      default: name = 24'h64656c;
    endcase
    unique case (pos)
      2'd0:    cmd_char = name[23:16];
      2'd1:    cmd_char = name[15:8];
      default: cmd_char = name[7:0];
    endcase
  endfunction

endpackage

### design/lpp_if.sv
interface lpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lpp_out_if;
  logic        valid;
  logic        ready;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [15:0] arg_index;
  logic        arg_first;
  logic        arg_last;
  logic        frame_done;
  logic [2:0]  verdict;

  modport source (output valid, output data_valid, output data_byte, output arg_index,
                  output arg_first, output arg_last, output frame_done, output verdict,
                  input ready);
  modport sink (input valid, input data_valid, input data_byte, input arg_index,
                input arg_first, input arg_last, input frame_done, input verdict,
                output ready);
endinterface

### design/lpp_cfg.sv
module lpp_cfg
  import lpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [31:0] max_body_len_r;
  logic [15:0] max_arg_count_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_len_r  <= MAX_BODY_LEN_RST;
      max_arg_count_r <= MAX_ARG_COUNT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MAX_BODY_LEN:  max_body_len_r  <= pwdata;
        REG_MAX_ARG_COUNT: max_arg_count_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_BODY_LEN:  prdata = max_body_len_r;
      REG_MAX_ARG_COUNT: prdata = {16'd0, max_arg_count_r};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg.max_body_len  = max_body_len_r;
  assign cfg.max_arg_count = max_arg_count_r;

endmodule

### design/lpp_core.sv
`include "length_prefixed_request_parser_top_defines.svh"

module lpp_core
  import lpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [31:0] hshift_r, hshift_nxt;
  logic [31:0] body_left_r, body_left_nxt;
  logic [15:0] args_left_r, args_left_nxt;
  logic [31:0] arg_bytes_left_r, arg_bytes_left_nxt;
  logic [15:0] cur_arg_r, cur_arg_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic        closed_r, closed_nxt;

  logic [7:0]  lc;
  logic        arg_fin;
  logic        item_fin;
  logic        fail;
  verdict_t    fail_code;

  always_comb begin
    phase_nxt          = phase_r;
    hcnt_nxt           = hcnt_r;
    hshift_nxt         = hshift_r;
    body_left_nxt      = body_left_r;
    args_left_nxt      = args_left_r;
    arg_bytes_left_nxt = arg_bytes_left_r;
    cur_arg_nxt        = cur_arg_r;
    pos_nxt            = pos_r;
    flags_nxt          = flags_r;
    closed_nxt         = closed_r;
    res                = '0;
    arg_fin            = 1'b0;
    item_fin           = 1'b0;
    fail               = 1'b0;
    fail_code          = V_BAD;
    lc                 = in_byte;

    if (!closed_r) begin
      if (phase_r == PH_DATA) begin
        if (in_byte >= 8'h41 && in_byte <= 8'h5a) begin
          lc = in_byte + 8'd32;
        end
        res.data_valid = 1'b1;
        res.data_byte  = in_byte;
        res.arg_index  = cur_arg_r;
        res.arg_first  = (arg_bytes_left_r == hshift_r);
        res.arg_last   = (arg_bytes_left_r == 32'd1);
        if (cur_arg_r == 16'd0) begin
          if (pos_r < 3'd3) begin
            for (int k = 0; k < 3; k++) begin
              if (lc != cmd_char(2'(k), pos_r[1:0])) begin
                flags_nxt[k] = 1'b0;
              end
            end
            pos_nxt = pos_r + 3'd1;
          end else begin
            flags_nxt = 3'b000;
          end
        end
        body_left_nxt      = body_left_r - 32'd1;
        arg_bytes_left_nxt = arg_bytes_left_r - 32'd1;
        arg_fin            = (arg_bytes_left_r == 32'd1);
      end else begin
        if (phase_r != PH_LEN) begin
          body_left_nxt = body_left_r - 32'd1;
        end
        hshift_nxt = {in_byte, hshift_r[31:8]};
        hcnt_nxt   = hcnt_r + 2'd1;
        if (hcnt_r == 2'd3) begin
          unique case (phase_r)
            PH_CNT: begin
              if (hshift_nxt > {16'd0, cfg.max_arg_count}) begin
                fail = 1'b1;
              end else begin
                args_left_nxt = hshift_nxt[15:0];
                cur_arg_nxt   = 16'd0;
                item_fin      = 1'b1;
              end
            end
            PH_SIZE: begin
              if (hshift_nxt > body_left_nxt) begin
                fail = 1'b1;
              end else begin
                if (cur_arg_r == 16'd0 && hshift_nxt != 32'd3) begin
                  flags_nxt = 3'b000;
                end
                if (hshift_nxt == 32'd0) begin
                  arg_fin = 1'b1;
                end else begin
                  arg_bytes_left_nxt = hshift_nxt;
                  phase_nxt          = PH_DATA;
                end
              end
            end
            default: begin
              if (hshift_nxt > cfg.max_body_len) begin
                fail      = 1'b1;
                fail_code = V_TOO_LONG;
              end else if (hshift_nxt < 32'd4) begin
                fail = 1'b1;
              end else begin
                body_left_nxt = hshift_nxt;
                phase_nxt     = PH_CNT;
              end
            end
          endcase
        end
      end

      if (arg_fin) begin
        cur_arg_nxt   = cur_arg_nxt + 16'd1;
        args_left_nxt = args_left_nxt - 16'd1;
        item_fin      = 1'b1;
      end

      // count header or argument complete: frame end, error or next size header
      if (item_fin) begin
        if (args_left_nxt == 16'd0) begin
          if (body_left_nxt != 32'd0) begin
            fail = 1'b1;
          end else begin
            res.frame_done = 1'b1;
            priority if (cur_arg_nxt == 16'd2 && flags_nxt[0]) begin
              res.verdict = V_GET;
            end else if (cur_arg_nxt == 16'd3 && flags_nxt[1]) begin
              res.verdict = V_SET;
            end else if (cur_arg_nxt == 16'd2 && flags_nxt[2]) begin
              res.verdict = V_DEL;
            end else begin
              res.verdict = V_UNKNOWN;
            end
            phase_nxt          = PH_LEN;
            hcnt_nxt           = 2'd0;
            hshift_nxt         = 32'd0;
            body_left_nxt      = 32'd0;
            args_left_nxt      = 16'd0;
            arg_bytes_left_nxt = 32'd0;
            cur_arg_nxt        = 16'd0;
            pos_nxt            = 3'd0;
            flags_nxt          = 3'b111;
          end
        end else if (body_left_nxt < 32'd4) begin
          fail = 1'b1;
        end else begin
          phase_nxt = PH_SIZE;
        end
      end

      if (fail) begin
        closed_nxt     = 1'b1;
        res.frame_done = 1'b1;
        res.verdict    = fail_code;
      end
    end
  end

  assign res_valid = res.data_valid || res.frame_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_LEN;
      hcnt_r           <= 2'd0;
      hshift_r         <= 32'd0;
      body_left_r      <= 32'd0;
      args_left_r      <= 16'd0;
      arg_bytes_left_r <= 32'd0;
      cur_arg_r        <= 16'd0;
      pos_r            <= 3'd0;
      flags_r          <= 3'b111;
      closed_r         <= 1'b0;
    end else if (step) begin
      phase_r          <= phase_nxt;
      hcnt_r           <= hcnt_nxt;
      hshift_r         <= hshift_nxt;
      body_left_r      <= body_left_nxt;
      args_left_r      <= args_left_nxt;
      arg_bytes_left_r <= arg_bytes_left_nxt;
      cur_arg_r        <= cur_arg_nxt;
      pos_r            <= pos_nxt;
      flags_r          <= flags_nxt;
      closed_r         <= closed_nxt;
    end
  end

  `LPP_ASSERT(a_closed_sticks, closed_r |=> closed_r, "parser reopened without reset")
  `LPP_ASSERT(a_closed_silent, closed_r |-> !res_valid, "result produced after an error")
  `LPP_ASSERT(a_too_long_on_len, (res.frame_done && res.verdict == V_TOO_LONG) |-> (phase_r == PH_LEN && hcnt_r == 2'd3), "too long flagged outside length header")

endmodule

### design/length_prefixed_request_parser_top.sv
// each accepted byte is held in the input register, and its result in the output register
// throughput: one byte per cycle; one byte-wide parser step per item, no back-pressure
// unless the result register is full and not being taken
// reset: rst_n synchronous active low; parser returns to the length header, limits
// return to 4096 body bytes and 1024 arguments, the error latch clears
`include "length_prefixed_request_parser_top_defines.svh"

module length_prefixed_request_parser_top
  import lpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lpp_in_if.sink      in_chan,
  lpp_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  result_t    res;
  logic       res_valid;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  result_t    out_r;
  logic       stage_free;
  logic       step;

  lpp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .in_byte   (in_byte_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // core may step when the result register is empty or being drained
  assign stage_free    = !out_valid_r || out_chan.ready;
  assign step          = in_valid_r && stage_free;
  assign in_chan.ready = !in_valid_r || stage_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_free) begin
      out_valid_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_free) begin
      out_r <= res;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.data_valid = out_r.data_valid;
  assign out_chan.data_byte  = out_r.data_byte;
  assign out_chan.arg_index  = out_r.arg_index;
  assign out_chan.arg_first  = out_r.arg_first;
  assign out_chan.arg_last   = out_r.arg_last;
  assign out_chan.frame_done = out_r.frame_done;
  assign out_chan.verdict    = out_r.verdict;

  `LPP_ASSERT(a_out_nonempty, out_valid_r |-> (out_r.data_valid || out_r.frame_done),
              "empty item in result register")
  `LPP_ASSERT(a_stall_needs_full, !in_chan.ready |-> in_valid_r,
              "input stalled with empty input register")
  `LPP_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!in_valid_r && !out_valid_r),
                     "pipeline not empty after reset")

endmodule

### tb/sv/length_prefixed_request_parser_top_tb.sv
`timescale 1ns / 1ps

module length_prefixed_request_parser_top_tb;
  import lpp_pkg::*;

  localparam logic [2:0] ADDR_BODY_LIMIT = {REG_MAX_BODY_LEN, 2'b00};
  localparam logic [2:0] ADDR_ARG_LIMIT = {REG_MAX_ARG_COUNT, 2'b00};
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;
  // index 0 get, 1 set, 2 del
  localparam logic [23:0] CMD_NAMES [3] = '{"get", "set", "del"};

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  lpp_in_if in_chan ();
  lpp_out_if out_chan ();

  length_prefixed_request_parser_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // parser copy: limits and frame state
  cfg_t lim;
  phase_t pstate;
  logic [1:0] hdr_n;
  logic [31:0] hdr_word;
  logic [31:0] body_rem;
  logic [15:0] args_rem;
  logic [31:0] arg_rem;
  logic [15:0] arg_no;
  logic [2:0] name_pos;
  logic [2:0] name_ok;
  logic locked;
  logic res_end;
  verdict_t res_code;

  result_t parse_results[$];
  logic [7:0] stream_q[$];
  logic [7:0] body_q[$];
  int bytes_queued = 0;
  int mismatch_cnt = 0;
  int stall_cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  function void put_stream(input logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endfunction

  function void put_body(input logic [7:0] b);
    body_q.insert(body_q.size(), b);
  endfunction

  function void put_expected(input result_t r);
    parse_results.insert(parse_results.size(), r);
  endfunction

  function void clear_frame();
    pstate = PH_LEN;
    hdr_n = '0;
    hdr_word = '0;
    body_rem = '0;
    args_rem = '0;
    arg_rem = '0;
    arg_no = '0;
    name_pos = '0;
    name_ok = 3'b111;
  endfunction

  function void close_on(input verdict_t code);
    locked = 1'b1;
    res_end = 1'b1;
    res_code = code;
  endfunction

  // count header or an argument fully taken in
  function void item_done();
    if (args_rem == 0) begin
      if (body_rem != 0) begin
        close_on(V_BAD);
      end else begin
        if (arg_no == 2 && name_ok[0]) res_code = V_GET;
        else if (arg_no == 3 && name_ok[1]) res_code = V_SET;
        else if (arg_no == 2 && name_ok[2]) res_code = V_DEL;
        else res_code = V_UNKNOWN;
        res_end = 1'b1;
        clear_frame();
      end
    end else if (body_rem < 4) begin
      close_on(V_BAD);
    end else begin
      pstate = PH_SIZE;
    end
  endfunction

  function void arg_done();
    arg_no = arg_no + 16'd1;
    args_rem = args_rem - 16'd1;
    item_done();
  endfunction

  function void parse_byte(input logic [7:0] b);
    result_t r;
    logic [7:0] lc;
    logic [31:0] w;
    int k;
    r = '0;
    res_end = 1'b0;
    res_code = '0;
    if (!locked) begin
      if (pstate == PH_DATA) begin
        r.data_valid = 1'b1;
        r.data_byte = b;
        r.arg_index = arg_no;
        r.arg_first = (arg_rem == hdr_word);
        r.arg_last = (arg_rem == 1);
        if (arg_no == 0) begin
          lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
          if (name_pos < 3) begin
            for (k = 0; k < 3; k++)
              if (lc != CMD_NAMES[k][8 * (2 - name_pos) +: 8]) name_ok[k] = 1'b0;
            name_pos = name_pos + 3'd1;
          end else begin
            name_ok = '0;
          end
        end
        body_rem = body_rem - 1;
        arg_rem = arg_rem - 1;
        if (arg_rem == 0) arg_done();
      end else begin
        if (pstate != PH_LEN) body_rem = body_rem - 1;
        hdr_word = {b, hdr_word[31:8]};
        hdr_n = hdr_n + 2'd1;
        if (hdr_n == 0) begin
          w = hdr_word;
          case (pstate)
            PH_CNT: begin
              if (w > lim.max_arg_count) begin
                close_on(V_BAD);
              end else begin
                args_rem = w[15:0];
                arg_no = '0;
                item_done();
              end
            end
            PH_SIZE: begin
              if (w > body_rem) begin
                close_on(V_BAD);
              end else begin
                if (arg_no == 0 && w != 3) name_ok = '0;
                if (w == 0) begin
                  arg_done();
                end else begin
                  arg_rem = w;
                  pstate = PH_DATA;
                end
              end
            end
            default: begin
              if (w > lim.max_body_len) close_on(V_TOO_LONG);
              else if (w < 4) close_on(V_BAD);
              else begin
                body_rem = w;
                pstate = PH_CNT;
              end
            end
          endcase
        end
      end
      if (r.data_valid || res_end) begin
        r.frame_done = res_end;
        r.verdict = res_end ? res_code : '0;
        put_expected(r);
      end
    end
  endfunction

  function void report_fault(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // byte source
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) parse_byte(in_chan.in_byte);
      if (!in_chan.valid || in_chan.ready) begin
        if (stream_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_chan.valid <= 1'b1;
          in_chan.in_byte <= stream_q.pop_front();
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // result sink and compare
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.data_valid = out_chan.data_valid;
        got.data_byte = out_chan.data_byte;
        got.arg_index = out_chan.arg_index;
        got.arg_first = out_chan.arg_first;
        got.arg_last = out_chan.arg_last;
        got.frame_done = out_chan.frame_done;
        got.verdict = out_chan.verdict;
        if (parse_results.size() == 0) begin
          report_fault($sformatf("unexpected item: dv=%0d byte=%02h idx=%0d done=%0d verdict=%0d",
                                 got.data_valid, got.data_byte, got.arg_index,
                                 got.frame_done, got.verdict));
        end else begin
          want = parse_results.pop_front();
          if (got.data_valid !== want.data_valid || got.data_byte !== want.data_byte ||
              got.arg_index !== want.arg_index || got.arg_first !== want.arg_first ||
              got.arg_last !== want.arg_last || got.frame_done !== want.frame_done ||
              got.verdict !== want.verdict)
            report_fault($sformatf({"mismatch: want dv=%0d byte=%02h idx=%0d f=%0d l=%0d ",
                                    "done=%0d v=%0d, got dv=%0d byte=%02h idx=%0d f=%0d ",
                                    "l=%0d done=%0d v=%0d"},
                                   want.data_valid, want.data_byte, want.arg_index,
                                   want.arg_first, want.arg_last, want.frame_done,
                                   want.verdict, got.data_valid, got.data_byte,
                                   got.arg_index, got.arg_first, got.arg_last,
                                   got.frame_done, got.verdict));
        end
      end
      out_chan.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (psel && penable && pwrite && pready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_BODY_LIMIT) lim.max_body_len = value;
    else lim.max_arg_count = value[15:0];
  endtask

  task automatic wait_drained();
    while (stream_q.size() != 0 || in_chan.valid || parse_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function void queue_word(input logic [31:0] w);
    int i;
    for (i = 0; i < 4; i++) put_stream(w[8 * i +: 8]);
    bytes_queued += 4;
  endfunction

  function void body_word(input logic [31:0] w);
    int i;
    for (i = 0; i < 4; i++) put_body(w[8 * i +: 8]);
  endfunction

  function void body_arg_str(input string s);
    int i;
    body_word(s.len());
    for (i = 0; i < s.len(); i++) put_body(s[i]);
  endfunction

  function void body_arg_rand(input int n);
    int i;
    body_word(n);
    for (i = 0; i < n; i++) put_body(8'($urandom_range(255)));
  endfunction

  // length header, then the body built so far
  function void post_frame();
    queue_word(body_q.size());
    while (body_q.size() != 0) put_stream(body_q.pop_front());
  endfunction

  // one well-formed request within the current limits
  task automatic queue_request();
    int style, cmd, nargs, tries, n, i, j;
    logic [7:0] c;
    for (tries = 0; tries < 8; tries++) begin
      body_q.delete();
      style = $urandom_range(9);
      cmd = $urandom_range(2);
      if (style <= 6) nargs = (cmd == 1) ? 3 : 2;
      else if (style == 7) nargs = (cmd == 1) ? 2 : 3;
      else if (style == 8) nargs = $urandom_range(6);
      else nargs = 0;
      if (nargs > lim.max_arg_count) nargs = lim.max_arg_count;
      body_word(nargs);
      for (i = 0; i < nargs; i++) begin
        if (i == 0 && style <= 7) begin
          // command name in mixed case, now and then one letter short or long
          n = 3;
          if ($urandom_range(9) == 0) n = $urandom_range(1) ? 2 : 4;
          body_word(n);
          for (j = 0; j < n; j++) begin
            if (j < 3) c = CMD_NAMES[cmd][8 * (2 - j) +: 8];
            else c = "s";
            if ($urandom_range(1)) c = c - 8'd32;
            put_body(c);
          end
        end else if (i == 0) begin
          // near misses: name letters mixed with arbitrary bytes
          n = $urandom_range(4);
          body_word(n);
          for (j = 0; j < n; j++) begin
            if ($urandom_range(1) && j < 3) c = CMD_NAMES[cmd][8 * (2 - j) +: 8];
            else c = 8'($urandom_range(255));
            put_body(c);
          end
        end else begin
          n = ($urandom_range(19) == 0) ? $urandom_range(60, 30) : $urandom_range(10);
          body_arg_rand(n);
        end
      end
      if (body_q.size() <= lim.max_body_len) break;
    end
    if (body_q.size() > lim.max_body_len) begin
      body_q.delete();
      body_word(0);
    end
    bytes_queued += body_q.size();
    post_frame();
  endtask

  task automatic queue_traffic(input int n);
    int stop_at;
    stop_at = bytes_queued + n;
    while (bytes_queued < stop_at) queue_request();
  endtask

  initial begin
    int body_cap, kind, extra, i;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_chan.valid = 1'b0;
    in_chan.in_byte = '0;
    out_chan.ready = 1'b0;
    lim.max_body_len = MAX_BODY_LEN_RST;
    lim.max_arg_count = MAX_ARG_COUNT_RST;
    locked = 1'b0;
    clear_frame();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 9;
    snk_idle_pct = 52;
    // mixed-case get whose last key byte also ends the frame, then an empty request
    body_word(2);
    body_arg_str("GeT");
    body_word(2);
    put_body(8'h00);
    put_body(8'hFF);
    bytes_queued += body_q.size();
    post_frame();
    body_word(0);
    bytes_queued += body_q.size();
    post_frame();
    queue_traffic(420);
    // sender holds off until every result is back
    wait_drained();
    queue_traffic(200);
    wait_drained();
    write_reg(ADDR_ARG_LIMIT, 32'd3);
    write_reg(ADDR_BODY_LIMIT, 32'hFFFF_FFFF);
    queue_traffic(250);
    wait_drained();

    src_idle_pct = 52;
    snk_idle_pct = 9;
    body_cap = $urandom_range(40, 16);
    write_reg(ADDR_BODY_LIMIT, body_cap);
    write_reg(ADDR_ARG_LIMIT, 32'h0000_FFFF);
    // body exactly at the limit
    body_word(2);
    body_arg_str("get");
    body_arg_rand(body_cap - 15);
    bytes_queued += body_q.size();
    post_frame();
    queue_traffic(380);
    wait_drained();
    write_reg(ADDR_ARG_LIMIT, 32'd0);
    write_reg(ADDR_BODY_LIMIT, 32'd4);
    queue_traffic(60);
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_reg(ADDR_BODY_LIMIT, $urandom_range(5000, 64));
    write_reg(ADDR_ARG_LIMIT, $urandom_range(1024, 4));
    queue_traffic(300);
    wait_drained();

    // one error closes the parser for the rest of the run
    kind = $urandom_range(4);
    extra = $urandom_range(7, 1);
    case (kind)
      0: begin
        if ($urandom_range(1)) write_reg(ADDR_BODY_LIMIT, 32'd0);
        queue_word(lim.max_body_len + 1 + $urandom_range(1000));
      end
      1: queue_word($urandom_range(3));
      2: begin
        queue_word(40);
        queue_word($urandom_range(1) ? 32'hFFFF_FFFF
                                     : lim.max_arg_count + 1 + $urandom_range(50));
      end
      3: begin
        if ($urandom_range(1)) begin
          queue_word(6);
          queue_word(1);
        end else begin
          extra = $urandom_range(20);
          queue_word(8 + extra);
          queue_word(1);
          queue_word(extra + 1 + $urandom_range(10));
        end
      end
      default: begin
        if ($urandom_range(1)) begin
          queue_word(4 + extra);
          queue_word(0);
        end else begin
          queue_word(10 + extra);
          queue_word(1);
          queue_word(2);
          put_stream(8'($urandom_range(255)));
          put_stream(8'($urandom_range(255)));
        end
      end
    endcase
    // bytes after the error must all be swallowed
    for (i = 0; i < 24; i++) put_stream(8'($urandom_range(255)));
    wait_drained();

    if (parse_results.size() != 0)
      report_fault($sformatf("%0d items never arrived", parse_results.size()));
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/lpp_pkg.sv
design/lpp_if.sv
design/lpp_cfg.sv
design/lpp_core.sv
design/length_prefixed_request_parser_top.sv
tb/sv/length_prefixed_request_parser_top_tb.sv
